// ----- hw/rtl/max_pool_2d_stream_assert.svh -----
// Assertion macros used by max_pool_2d_stream.
`ifndef MAX_POOL_2D_STREAM_ASSERT_SVH
`define MAX_POOL_2D_STREAM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MP2D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define MP2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/mp2d_pkg.sv -----
package mp2d_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_KERNEL  = 7;
    localparam int SAMPLE_BITS = 16;

    localparam int LS_DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int ADDR_W   = $clog2(LS_DEPTH);
    localparam int SLOT_W   = $clog2(MAX_KERNEL);
    localparam int POS_W    = $clog2(MAX_WIDTH);
    localparam int DIM_W    = 9;
    localparam int END_W    = 12;
    localparam int IDX_W    = 9;

    localparam logic [2:0] REG_KERNEL  = 3'd0;
    localparam logic [2:0] REG_STRIDE  = 3'd1;
    localparam logic [2:0] REG_PADDING = 3'd2;
    localparam logic [2:0] REG_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_WIDTH   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/max_pool_2d_stream.sv -----
// Channel    | Direction | Contents
// s_*        | in        | tdata[15:0] sample
// m_*        | out       | tdata pooled, out_row, out_col; tlast run_last; tuser plane_done
// p*         | in/out    | register writes and reads
// A sample is accepted only in the idle state, so the next one waits until every
// window it closes has been scanned; each window is read element by element
// through the single read port of the line store.
// Reset clears position, window bases and the output valid flag; the line store
// is not cleared. The output register lets results wait while scanning goes on.
`include "max_pool_2d_stream_assert.svh"

module max_pool_2d_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] pooled, [23:16] out_row, [31:24] out_col
    output logic        m_tlast,
    output logic        m_tuser,   // [0] plane_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mp2d_pkg::*;

    logic [2:0] kern_reg, strd_reg, pad_reg;
    logic [DIM_W-1:0] hgt_reg, wid_reg;

    logic [2:0] k3, s3, p3;
    logic [DIM_W-1:0] h9, w9;
    logic [END_W-1:0] lim_h, lim_w, first_end, hm1, wm1;

    state_t state_reg, state_next;

    logic [POS_W-1:0] r_reg, c_reg, cur_r_reg, cur_c_reg;
    logic [SLOT_W-1:0] slot_reg, cur_slot_reg;
    logic [IDX_W-1:0] rb_reg, cb_reg, oh_reg, ow_reg, oh_next, ow_next;
    logic [END_W-1:0] rbe_reg, cbe_reg, ohe_reg, owe_reg, ohe_next, owe_next;
    logic [POS_W-1:0] r0_reg, r0_next, rr_reg, rr_next, cc_reg, cc_next;
    logic [SLOT_W-1:0] st_slot_reg, st_slot_next, rs_reg, rs_next;
    logic signed [SAMPLE_BITS-1:0] acc_reg, acc_next, rdata_reg;
    logic acc_v_reg, acc_v_next, rd_v_reg, issue;
    logic setup;

    logic [SAMPLE_BITS-1:0] mem [LS_DEPTH];
    logic [ADDR_W-1:0] raddr, waddr;

    logic cfg_we, cfg_hit, acc_in, load_out;
    logic ncv, nrv, rv, cv;
    logic [END_W-1:0] ohe_s, owe_s, win_ohe, win_owe, km1;
    logic [POS_W-1:0] win_r0, win_c0;
    logic [SLOT_W-1:0] slot_dist;

    logic mv_reg;
    logic [31:0] mdata_reg;
    logic mlast_reg, muser_reg;

    function automatic logic row_ok(input logic [END_W-1:0] e, input logic [END_W-1:0] lim,
                                    input logic [END_W-1:0] last, input logic [POS_W-1:0] pos);
        logic [END_W-1:0] cl;
        cl = (e >= last) ? last : e;
        return (e <= lim) && (cl == END_W'(pos));
    endfunction

    assign cfg_we = psel && penable && pwrite && pready;
    assign cfg_hit = (paddr[4:2] <= REG_WIDTH);
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_KERNEL:  prdata = 32'(kern_reg);
            REG_STRIDE:  prdata = 32'(strd_reg);
            REG_PADDING: prdata = 32'(pad_reg);
            REG_HEIGHT:  prdata = 32'(hgt_reg);
            REG_WIDTH:   prdata = 32'(wid_reg);
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kern_reg <= 3'd3;
            strd_reg <= 3'd2;
            pad_reg  <= 3'd1;
            hgt_reg  <= DIM_W'(112);
            wid_reg  <= DIM_W'(112);
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_KERNEL:  kern_reg <= pwdata[2:0];
                REG_STRIDE:  strd_reg <= pwdata[2:0];
                REG_PADDING: pad_reg  <= pwdata[2:0];
                REG_HEIGHT:  hgt_reg  <= pwdata[DIM_W-1:0];
                REG_WIDTH:   wid_reg  <= pwdata[DIM_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        k3 = (kern_reg == 3'd0) ? 3'd1 : kern_reg;
        s3 = (strd_reg == 3'd0) ? 3'd1 : strd_reg;
        p3 = (pad_reg > k3 - 3'd1) ? k3 - 3'd1 : pad_reg;
        h9 = (hgt_reg == '0) ? DIM_W'(1)
           : ((hgt_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : hgt_reg);
        w9 = (wid_reg == '0) ? DIM_W'(1)
           : ((wid_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : wid_reg);
        hm1 = END_W'(h9) - END_W'(1);
        wm1 = END_W'(w9) - END_W'(1);
        lim_h = hm1 + END_W'(p3);
        lim_w = wm1 + END_W'(p3);
        km1 = END_W'(k3) - END_W'(1);
        first_end = END_W'(k3 - 3'd1 - p3);
    end

    assign acc_in = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign waddr = ADDR_W'(slot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_reg);
    assign raddr = ADDR_W'(rs_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cc_reg);
    assign issue = (state_reg == ST_SCAN);

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            mem[waddr] <= s_tdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Position of the next sample and the first output row and column not yet closed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
            c_reg <= '0;
            slot_reg <= '0;
            cur_r_reg <= '0;
            cur_c_reg <= '0;
            cur_slot_reg <= '0;
            rb_reg <= '0;
            rbe_reg <= '0;
            cb_reg <= '0;
            cbe_reg <= '0;
        end
        else if (cfg_we && cfg_hit)
        begin
            r_reg <= '0;
            c_reg <= '0;
            slot_reg <= '0;
        end
        else if (acc_in)
        begin
            cur_r_reg <= r_reg;
            cur_c_reg <= c_reg;
            cur_slot_reg <= slot_reg;
            if (c_reg == '0)
            begin
                cb_reg <= '0;
                cbe_reg <= first_end;
                if (r_reg == '0)
                begin
                    rb_reg <= '0;
                    rbe_reg <= first_end;
                end
                else if (rbe_reg < END_W'(r_reg))
                begin
                    rb_reg <= rb_reg + IDX_W'(1);
                    rbe_reg <= rbe_reg + END_W'(s3);
                end
            end
            else if (cbe_reg < END_W'(c_reg))
            begin
                cb_reg <= cb_reg + IDX_W'(1);
                cbe_reg <= cbe_reg + END_W'(s3);
            end
            if (DIM_W'(c_reg) + DIM_W'(1) >= w9)
            begin
                c_reg <= '0;
                if (DIM_W'(r_reg) + DIM_W'(1) >= h9)
                begin
                    r_reg <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    r_reg <= r_reg + POS_W'(1);
                    slot_reg <= (slot_reg == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                c_reg <= c_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        ohe_s = ohe_reg + END_W'(s3);
        owe_s = owe_reg + END_W'(s3);
        rv  = row_ok(rbe_reg, lim_h, hm1, cur_r_reg);
        cv  = row_ok(cbe_reg, lim_w, wm1, cur_c_reg);
        ncv = row_ok(owe_s, lim_w, wm1, cur_c_reg);
        nrv = row_ok(ohe_s, lim_h, hm1, cur_r_reg);
        load_out = (state_reg == ST_OUT) && (!mv_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        oh_next = oh_reg;
        ow_next = ow_reg;
        ohe_next = ohe_reg;
        owe_next = owe_reg;
        setup = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_in)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (rv && cv)
                begin
                    oh_next = rb_reg;
                    ohe_next = rbe_reg;
                    ow_next = cb_reg;
                    owe_next = cbe_reg;
                    setup = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (rr_reg == cur_r_reg && cc_reg == cur_c_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    priority if (ncv)
                    begin
                        ow_next = ow_reg + IDX_W'(1);
                        owe_next = owe_s;
                        setup = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else if (nrv)
                    begin
                        oh_next = oh_reg + IDX_W'(1);
                        ohe_next = ohe_s;
                        ow_next = cb_reg;
                        owe_next = cbe_reg;
                        setup = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Window origin clipped to the image and line-store slot of its top row; scan and max.
    always_comb
    begin
        win_ohe = ohe_next;
        win_owe = owe_next;
        win_r0 = (win_ohe < km1) ? '0 : POS_W'(win_ohe - km1);
        win_c0 = (win_owe < km1) ? '0 : POS_W'(win_owe - km1);
        slot_dist = SLOT_W'(cur_r_reg - win_r0);
        st_slot_next = (cur_slot_reg >= slot_dist) ? cur_slot_reg - slot_dist
                                                   : cur_slot_reg + SLOT_W'(MAX_KERNEL) - slot_dist;
        r0_next = r0_reg;
        rr_next = rr_reg;
        rs_next = rs_reg;
        cc_next = cc_reg;
        if (setup)
        begin
            r0_next = win_r0;
            rr_next = win_r0;
            rs_next = st_slot_next;
            cc_next = win_c0;
        end
        else if (issue)
        begin
            if (rr_reg == cur_r_reg)
            begin
                rr_next = r0_reg;
                rs_next = st_slot_reg;
                cc_next = cc_reg + POS_W'(1);
            end
            else
            begin
                rr_next = rr_reg + POS_W'(1);
                rs_next = (rs_reg == SLOT_W'(MAX_KERNEL - 1)) ? '0 : rs_reg + SLOT_W'(1);
            end
        end
        acc_next = acc_reg;
        acc_v_next = acc_v_reg;
        if (setup)
        begin
            acc_v_next = 1'b0;
        end
        else if (rd_v_reg)
        begin
            if (!acc_v_reg || rdata_reg > acc_reg)
            begin
                acc_next = rdata_reg;
            end
            acc_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_v_reg <= 1'b0;
            acc_v_reg <= 1'b0;
            mv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg <= issue;
            acc_v_reg <= acc_v_next;
            if (load_out)
            begin
                mv_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oh_reg <= oh_next;
        ow_reg <= ow_next;
        ohe_reg <= ohe_next;
        owe_reg <= owe_next;
        r0_reg <= r0_next;
        rr_reg <= rr_next;
        rs_reg <= rs_next;
        cc_reg <= cc_next;
        acc_reg <= acc_next;
        if (setup)
        begin
            st_slot_reg <= st_slot_next;
        end
        if (load_out)
        begin
            mdata_reg <= {ow_reg[7:0], oh_reg[7:0], acc_reg};
            mlast_reg <= !ncv && !nrv;
            muser_reg <= (ohe_s > lim_h) && (owe_s > lim_w);
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = mdata_reg;
    assign m_tlast = mlast_reg;
    assign m_tuser = muser_reg;

    `MP2D_ASSERT_NOW(a_acc_ready, state_reg == ST_OUT, acc_v_reg)
    `MP2D_ASSERT_NOW(a_slot_range, 1'b1, slot_reg < SLOT_W'(MAX_KERNEL))
    `MP2D_ASSERT_NOW(a_scan_rows, state_reg == ST_SCAN, rr_reg <= cur_r_reg && cc_reg <= cur_c_reg)
    `MP2D_ASSERT_NEXT(a_read_follows, state_reg == ST_SCAN, rd_v_reg)

endmodule
